### rtl/core/fpt_pkg.sv
// types, codes and constants shared by the page table manager
package fpt_pkg;

  localparam int unsigned PaWidth   = 52;
  localparam int unsigned VaWidth   = 48;
  localparam int unsigned FlagWidth = 12;
  localparam int unsigned IdxWidth  = 9;
  localparam int unsigned PageShift = 12;
  localparam int unsigned EntryWidth = 64;

  localparam logic [EntryWidth-1:0] BitPresent = 64'h1;
  localparam logic [EntryWidth-1:0] BitWrite   = 64'h2;
  localparam logic [EntryWidth-1:0] BitUser    = 64'h4;

  // byte address of the pool base register
  localparam logic [2:0] AddrPoolBase = 3'd0;

  typedef enum logic [1:0] {
    OpMap       = 2'd0,
    OpUnmap     = 2'd1,
    OpTranslate = 2'd2,
    OpNone      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StUnmapped = 2'd1,
    StNoPages  = 2'd2,
    StUnused   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SInit,
    SIdle,
    SRead,
    SCheck,
    SClear,
    SLink,
    SPtr,
    SLeafRead,
    SLeafCheck
  } state_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [VaWidth-1:0]   va;
    logic [PaWidth-1:0]   pa;
    logic [FlagWidth-1:0] flags;
  } cmd_t;

  typedef struct packed {
    logic [PaWidth-1:0] phys_result;
    logic [1:0]         status;
  } rsp_t;

endpackage

### rtl/core/four_level_page_table_manager_core.sv
// four-level page table manager: walk sequencer over one table memory
// Steps: an unknown op finishes straight from idle; a walk with no allocation runs
// three levels of read, check and pointer decode, then the leaf, and every level
// allocated adds the clearing of all 512 entries of the new table and its link.
// One word at a time; busy_o stays high until the result strobe is issued.
// After reset the table memory (TABLE_PAGES * 512 entries, 4096 by default)
// is cleared one entry a cycle, with busy_o high; config writes are taken.
module four_level_page_table_manager_core #(
  parameter int unsigned TABLE_PAGES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fpt_pkg::cmd_t      cmd_i,
  output logic               busy_o,
  output logic               done_o,
  output fpt_pkg::rsp_t      rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AW    = PW + fpt_pkg::IdxWidth;
  localparam int unsigned Depth = TABLE_PAGES * 512;
  localparam int unsigned FW    = fpt_pkg::PaWidth - fpt_pkg::PageShift;

  fpt_pkg::state_e state_q, state_d;
  fpt_pkg::cmd_t   cmd_q, cmd_d;
  fpt_pkg::rsp_t   res_q, res_d;
  logic            done_q, done_d;
  logic [1:0]      lvl_q, lvl_d;
  logic [PW-1:0]   page_q, page_d;
  logic [PW-1:0]   np_q, np_d;
  logic [NW-1:0]   nfp_q, nfp_d;
  logic [8:0]      clr_q, clr_d;
  logic [AW-1:0]   init_q, init_d;
  logic [AW-1:0]   slot_q, slot_d;
  logic [63:0]     entry_q, entry_d;
  logic [fpt_pkg::PaWidth-1:0] base_q;
  logic [63:0]     rdata_q;

  logic [63:0]     mem [Depth];
  logic            we;
  logic [AW-1:0]   waddr;
  logic [63:0]     wdata;
  logic [AW-1:0]   raddr;
  logic [8:0]      idx;
  logic [FW-1:0]   off;
  logic [FW-1:0]   new_frame;
  logic [63:0]     user_bit;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == fpt_pkg::AddrPoolBase) ? {12'b0, base_q} : 64'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite) begin
      base_q <= pwdata[fpt_pkg::PaWidth-1:0];
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // index field of the current level
  always_comb begin
    case (lvl_q)
      2'd0:    idx = cmd_q.va[47:39];
      2'd1:    idx = cmd_q.va[38:30];
      2'd2:    idx = cmd_q.va[29:21];
      default: idx = cmd_q.va[20:12];
    endcase
  end

  assign raddr     = {page_q, idx};
  assign off       = entry_q[fpt_pkg::PaWidth-1:fpt_pkg::PageShift]
                     - base_q[fpt_pkg::PaWidth-1:fpt_pkg::PageShift];
  assign new_frame = base_q[fpt_pkg::PaWidth-1:fpt_pkg::PageShift] + FW'(np_q);
  assign user_bit  = cmd_q.flags[2] ? fpt_pkg::BitUser : 64'h0;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    done_d  = 1'b0;
    lvl_d   = lvl_q;
    page_d  = page_q;
    np_d    = np_q;
    nfp_d   = nfp_q;
    clr_d   = clr_q;
    init_d  = init_q;
    slot_d  = slot_q;
    entry_d = entry_q;
    we      = 1'b0;
    waddr   = slot_q;
    wdata   = '0;
    case (state_q)
      fpt_pkg::SInit: begin
        we     = 1'b1;
        waddr  = init_q;
        init_d = init_q + AW'(1);
        if (init_q == AW'(Depth - 1)) begin
          state_d = fpt_pkg::SIdle;
        end
      end
      fpt_pkg::SIdle: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          lvl_d  = 2'd0;
          page_d = '0;
          if (cmd_i.op == fpt_pkg::OpNone) begin
            res_d.phys_result = '0;
            res_d.status      = fpt_pkg::StUnmapped;
            done_d            = 1'b1;
          end else begin
            state_d = fpt_pkg::SRead;
          end
        end
      end
      fpt_pkg::SRead: begin
        slot_d  = raddr;
        state_d = fpt_pkg::SCheck;
      end
      fpt_pkg::SCheck: begin
        if (!rdata_q[0]) begin
          if (cmd_q.op != fpt_pkg::OpMap) begin
            res_d.phys_result = '0;
            res_d.status      = fpt_pkg::StUnmapped;
            done_d            = 1'b1;
            state_d           = fpt_pkg::SIdle;
          end else if (nfp_q >= NW'(TABLE_PAGES)) begin
            res_d.phys_result = '0;
            res_d.status      = fpt_pkg::StNoPages;
            done_d            = 1'b1;
            state_d           = fpt_pkg::SIdle;
          end else begin
            np_d    = nfp_q[PW-1:0];
            nfp_d   = nfp_q + NW'(1);
            clr_d   = '0;
            state_d = fpt_pkg::SClear;
          end
        end else begin
          entry_d = rdata_q | user_bit;
          if (cmd_q.op == fpt_pkg::OpMap && cmd_q.flags[2]) begin
            we    = 1'b1;
            wdata = rdata_q | fpt_pkg::BitUser;
          end
          state_d = fpt_pkg::SPtr;
        end
      end
      fpt_pkg::SClear: begin
        // wipe the freshly taken table page
        we    = 1'b1;
        waddr = {np_q, clr_q};
        clr_d = clr_q + 9'd1;
        if (clr_q == 9'd511) begin
          state_d = fpt_pkg::SLink;
        end
      end
      fpt_pkg::SLink: begin
        entry_d = {12'b0, new_frame, 12'b0} | fpt_pkg::BitPresent
                  | fpt_pkg::BitWrite | user_bit;
        we      = 1'b1;
        wdata   = entry_d;
        state_d = fpt_pkg::SPtr;
      end
      fpt_pkg::SPtr: begin
        // decode the pointer back to a pool page
        if (off >= FW'(TABLE_PAGES)) begin
          res_d.phys_result = '0;
          res_d.status      = fpt_pkg::StUnmapped;
          done_d            = 1'b1;
          state_d           = fpt_pkg::SIdle;
        end else begin
          page_d = off[PW-1:0];
          lvl_d  = lvl_q + 2'd1;
          state_d = (lvl_q == 2'd2) ? fpt_pkg::SLeafRead : fpt_pkg::SRead;
        end
      end
      fpt_pkg::SLeafRead: begin
        slot_d  = raddr;
        state_d = fpt_pkg::SLeafCheck;
      end
      fpt_pkg::SLeafCheck: begin
        done_d            = 1'b1;
        state_d           = fpt_pkg::SIdle;
        res_d.phys_result = '0;
        res_d.status      = fpt_pkg::StOk;
        case (cmd_q.op)
          fpt_pkg::OpMap: begin
            we    = 1'b1;
            wdata = {12'b0, cmd_q.pa[fpt_pkg::PaWidth-1:fpt_pkg::PageShift],
                     cmd_q.flags | 12'h001};
          end
          fpt_pkg::OpUnmap: begin
            if (rdata_q[0]) begin
              we    = 1'b1;
              wdata = '0;
            end else begin
              res_d.status = fpt_pkg::StUnmapped;
            end
          end
          fpt_pkg::OpTranslate: begin
            if (rdata_q[0]) begin
              res_d.phys_result = {rdata_q[fpt_pkg::PaWidth-1:fpt_pkg::PageShift],
                                   cmd_q.va[11:0]};
            end else begin
              res_d.status = fpt_pkg::StUnmapped;
            end
          end
          default: begin
            res_d.status = fpt_pkg::StUnmapped;
          end
        endcase
      end
      default: begin
        state_d = fpt_pkg::SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpt_pkg::SInit;
      done_q  <= 1'b0;
      lvl_q   <= '0;
      page_q  <= '0;
      nfp_q   <= NW'(1);
      clr_q   <= '0;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      lvl_q   <= lvl_d;
      page_q  <= page_d;
      nfp_q   <= nfp_d;
      clr_q   <= clr_d;
      init_q  <= init_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    np_q    <= np_d;
    slot_q  <= slot_d;
    entry_q <= entry_d;
  end

  assign busy_o = (state_q != fpt_pkg::SIdle);
  assign done_o = done_q;
  assign rsp_o  = res_q;

`ifndef ASSERT_OFF
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfp_q <= NW'(TABLE_PAGES))
    else $error("free page count beyond pool");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status != fpt_pkg::StUnused))
    else $error("result word carries an unused status code");
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != fpt_pkg::StOk) |-> (rsp_o.phys_result == '0))
    else $error("failed word carries an address");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while walk still running");
`endif

endmodule
